// ===== hdl/bdsf_pkg.sv =====
package bdsf_pkg;

    localparam int unsigned MAX_DEPTH = 64;
    localparam int unsigned DEPTH_W   = 7;
    localparam int unsigned POS_W     = 32;

    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_E     = 8'h65;  // 'e'
    localparam logic [7:0] CH_I     = 8'h69;  // 'i'
    localparam logic [7:0] CH_L     = 8'h6C;  // 'l'
    localparam logic [7:0] CH_D     = 8'h64;  // 'd'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    typedef enum logic [2:0] {
        MODE_WAIT_D     = 3'd0,
        MODE_ITEM       = 3'd1,
        MODE_LEN        = 3'd2,
        MODE_BODY       = 3'd3,
        MODE_INT_START  = 3'd4,
        MODE_INT_DIGITS = 3'd5,
        MODE_DONE       = 3'd6,
        MODE_ERROR      = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_PAIR  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] key_start;
        logic [POS_W-1:0] key_len;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_end;
    } t_result;

endpackage

// ===== hdl/bencode_top_dict_span_finder_unit.sv =====
// Finds the key/value pairs of a bencoded outer dictionary, one stream byte
// per clock while the output does not stall. Bytes enter on i_valid/o_stall
// starting with the outer 'd'; each top-level pair yields one request on
// o_valid/i_stall with the key's offset and length and the value's begin and
// end offsets, the offsets plus start_offset. The outer closing 'e' yields a
// done request, malformed input or nesting past 64 levels an error request;
// after either, bytes are swallowed without output until reset. A byte is
// held in the input register; when it is taken, the parse state updates and
// its request is registered in the output register. A stalled output holds
// the input register and then o_stall.
// Write start_offset through i_cfg_valid only while the unit is idle.
module bencode_top_dict_span_finder_unit import bdsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_data_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output logic [POS_W-1:0] o_key_start,
    output logic [POS_W-1:0] o_key_len,
    output logic [POS_W-1:0] o_value_start,
    output logic [POS_W-1:0] o_value_end,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [POS_W-1:0] i_cfg_start_offset
);

    logic [POS_W-1:0] r_start_offset;
    logic             held_vld;
    logic [7:0]       held_byte;
    logic             take;
    logic             res_vld;
    t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_offset <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_start_offset <= i_cfg_start_offset;
        end
    end

    // advance the held byte only when the result slot is free or draining
    assign take = held_vld && (!o_valid || !i_stall);

    bdsf_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .o_stall     (o_stall),
        .i_take      (take),
        .o_held_vld  (held_vld),
        .o_held_byte (held_byte)
    );

    bdsf_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (take),
        .i_byte         (held_byte),
        .i_start_offset (r_start_offset),
        .o_res_vld      (res_vld),
        .o_res          (res)
    );

    bdsf_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (res_vld),
        .i_res         (res),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_key_start   (o_key_start),
        .o_key_len     (o_key_len),
        .o_value_start (o_value_start),
        .o_value_end   (o_value_end)
    );

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> (!o_valid || !i_stall))
        else $error("result loaded over a stalled request");

endmodule

// ===== hdl/bdsf_in_stage.sv =====
module bdsf_in_stage import bdsf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    output logic       o_stall,
    input  logic       i_take,
    output logic       o_held_vld,
    output logic [7:0] o_held_byte
);

    logic       r_vld;
    logic       n_vld;
    logic [7:0] r_byte;
    logic       accept;

    assign o_stall = r_vld && !i_take;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (i_take) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_held_vld  = r_vld;
    assign o_held_byte = r_byte;

endmodule

// ===== hdl/bdsf_parse.sv =====
module bdsf_parse import bdsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [7:0]       i_byte,
    input  logic [POS_W-1:0] i_start_offset,
    output logic             o_res_vld,
    output t_result          o_res
);

    t_mode              r_mode,  n_mode;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [POS_W-1:0]   r_accum, n_accum;
    logic [POS_W-1:0]   r_body,  n_body;
    logic [POS_W-1:0]   r_pos,   n_pos;
    logic               r_kp,    n_kp;
    logic [POS_W-1:0]   r_key_start, n_key_start;
    logic [POS_W-1:0]   r_key_len,   n_key_len;
    logic [POS_W-1:0]   r_val_start, n_val_start;

    logic [POS_W-1:0]   nxt_pos;
    logic               is_digit;
    logic [POS_W-1:0]   digit_val;
    logic [POS_W+3:0]   accum_x10;
    logic [POS_W-1:0]   accum_sat;
    logic [DEPTH_W-1:0] depth_dec;
    logic [POS_W-1:0]   body_dec;
    logic               sc_fire;
    logic               sc_str;
    logic [POS_W-1:0]   sc_len;
    logic               emit_pair;
    logic               emit_done;
    logic               emit_err;

    assign nxt_pos   = r_pos + 1'b1;
    assign is_digit  = i_byte inside {[CH_ZERO:CH_NINE]};
    assign digit_val = {{(POS_W-4){1'b0}}, 4'(i_byte - CH_ZERO)};
    assign accum_x10 = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1)
                       + {4'b0, digit_val};
    assign accum_sat = (accum_x10[POS_W+3:POS_W] != 4'b0) ? {POS_W{1'b1}}
                                                          : accum_x10[POS_W-1:0];
    assign depth_dec = r_depth - 1'b1;
    assign body_dec  = r_body - 1'b1;

    // next state
    always_comb begin
        n_mode      = r_mode;
        n_depth     = r_depth;
        n_accum     = r_accum;
        n_body      = r_body;
        n_pos       = r_pos;
        n_kp        = r_kp;
        n_key_start = r_key_start;
        n_key_len   = r_key_len;
        n_val_start = r_val_start;
        sc_fire     = 1'b0;
        sc_str      = 1'b0;
        sc_len      = '0;
        emit_pair   = 1'b0;
        emit_done   = 1'b0;
        emit_err    = 1'b0;

        if (i_go && r_mode != MODE_DONE && r_mode != MODE_ERROR) begin
            n_pos = nxt_pos;
            case (r_mode)
                MODE_WAIT_D: begin
                    if (i_byte != CH_D) begin
                        emit_err = 1'b1;
                    end else begin
                        n_depth = DEPTH_W'(1);
                        n_mode  = MODE_ITEM;
                    end
                end
                MODE_ITEM: begin
                    if (i_byte == CH_E) begin
                        n_depth = depth_dec;
                        if (depth_dec == '0) begin
                            n_mode    = MODE_DONE;
                            n_kp      = 1'b0;
                            emit_done = 1'b1;
                        end else if (depth_dec == DEPTH_W'(1) && r_kp) begin
                            emit_pair = 1'b1;
                        end
                    end else if (i_byte == CH_I) begin
                        n_mode = MODE_INT_START;
                    end else if (is_digit) begin
                        n_accum = digit_val;
                        n_mode  = MODE_LEN;
                    end else if (i_byte == CH_L || i_byte == CH_D) begin
                        if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                            emit_err = 1'b1;
                        end else begin
                            n_depth = r_depth + 1'b1;
                        end
                    end else begin
                        emit_err = 1'b1;
                    end
                end
                MODE_LEN: begin
                    if (i_byte == CH_COLON) begin
                        if (r_depth == DEPTH_W'(1) && !r_kp) begin
                            n_key_start = nxt_pos;
                        end
                        if (r_accum == '0) begin
                            sc_fire = 1'b1;
                            sc_str  = 1'b1;
                        end else begin
                            n_body = r_accum;
                            n_mode = MODE_BODY;
                        end
                    end else if (is_digit) begin
                        n_accum = accum_sat;
                    end else begin
                        emit_err = 1'b1;
                    end
                end
                MODE_BODY: begin
                    n_body = body_dec;
                    if (body_dec == '0) begin
                        sc_fire = 1'b1;
                        sc_str  = 1'b1;
                        sc_len  = r_accum;
                    end
                end
                MODE_INT_START: begin
                    if (i_byte == CH_MINUS || is_digit) begin
                        n_mode = MODE_INT_DIGITS;
                    end else begin
                        sc_fire = 1'b1;
                    end
                end
                MODE_INT_DIGITS: begin
                    if (!is_digit) begin
                        sc_fire = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // finish a scalar: at the top level, pair it with a pending key or hold a string as the key
            if (sc_fire) begin
                n_mode = MODE_ITEM;
                if (r_depth == DEPTH_W'(1)) begin
                    if (r_kp) begin
                        emit_pair = 1'b1;
                    end else if (sc_str) begin
                        n_kp        = 1'b1;
                        n_key_len   = sc_len;
                        n_val_start = nxt_pos;
                    end
                end
            end
            if (emit_pair) begin
                n_kp = 1'b0;
            end
            if (emit_err) begin
                n_mode = MODE_ERROR;
            end
        end
    end

    // result
    always_comb begin
        o_res_vld = emit_pair || emit_done || emit_err;
        o_res     = '0;
        if (emit_pair) begin
            o_res.status      = ST_PAIR;
            o_res.key_start   = i_start_offset + r_key_start;
            o_res.key_len     = r_key_len;
            o_res.value_start = i_start_offset + r_val_start;
            o_res.value_end   = i_start_offset + nxt_pos;
        end else if (emit_done) begin
            o_res.status = ST_DONE;
        end else if (emit_err) begin
            o_res.status = ST_ERROR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT_D;
            r_depth     <= '0;
            r_accum     <= '0;
            r_body      <= '0;
            r_pos       <= '0;
            r_kp        <= 1'b0;
            r_key_start <= '0;
            r_key_len   <= '0;
            r_val_start <= '0;
        end else begin
            r_mode      <= n_mode;
            r_depth     <= n_depth;
            r_accum     <= n_accum;
            r_body      <= n_body;
            r_pos       <= n_pos;
            r_kp        <= n_kp;
            r_key_start <= n_key_start;
            r_key_len   <= n_key_len;
            r_val_start <= n_val_start;
        end
    end

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DONE || r_mode == MODE_ERROR) |=> $stable(r_mode))
        else $error("parser left a terminal mode");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth above limit");

    a_item_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_ITEM || r_mode == MODE_LEN || r_mode == MODE_BODY)
        |-> r_depth != '0)
        else $error("parsing an item outside the outer dictionary");

    a_res_needs_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> i_go)
        else $error("result without a byte");

endmodule

// ===== hdl/bdsf_out_stage.sv =====
module bdsf_out_stage import bdsf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_result          i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [1:0]       o_status,
    output logic [POS_W-1:0] o_key_start,
    output logic [POS_W-1:0] o_key_len,
    output logic [POS_W-1:0] o_value_start,
    output logic [POS_W-1:0] o_value_end
);

    logic    r_vld;
    logic    n_vld;
    t_result r_res;

    always_comb begin
        n_vld = r_vld;
        if (i_load) begin
            n_vld = 1'b1;
        end else if (!i_stall) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid       = r_vld;
    assign o_status      = r_res.status;
    assign o_key_start   = r_res.key_start;
    assign o_key_len     = r_res.key_len;
    assign o_value_start = r_res.value_start;
    assign o_value_end   = r_res.value_end;

endmodule
